### rtl/wbcs_pkg.sv
// Shared types and constants for the white blob centroid steering block.
package wbcs_pkg;

  // Fixed field widths of the block's interface and datapath.
  localparam int unsigned PixW    = 8;
  localparam int unsigned CountW  = 21;
  localparam int unsigned SumW    = 30;
  localparam int unsigned ColOutW = 10;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 21;
  localparam int unsigned IterW   = $clog2(SumW);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegFrameWidth   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBandFirstRow = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBandLastRow  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWhiteLevel   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLeftBound    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRightBound   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegNearCount    = 3'd6;

  // Register reset values.
  localparam logic [10:0]       FrameWidthRst   = 11'd800;
  localparam logic [9:0]        BandFirstRowRst = 10'd300;
  localparam logic [9:0]        BandLastRowRst  = 10'd499;
  localparam logic [PixW-1:0]   WhiteLevelRst   = 8'd255;
  localparam logic [9:0]        LeftBoundRst    = 10'd350;
  localparam logic [9:0]        RightBoundRst   = 10'd450;
  localparam logic [CountW-1:0] NearCountRst    = 21'd40000;

  // Largest centroid column that is reported.
  localparam logic [ColOutW-1:0] CenterMax = 10'd1023;

  // Steering codes.
  typedef enum logic [1:0] {
    STEER_STOP    = 2'd0,
    STEER_LEFT    = 2'd1,
    STEER_FORWARD = 2'd2,
    STEER_RIGHT   = 2'd3
  } steer_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_ACCUM  = 2'd0,
    ST_DIVIDE = 2'd1,
    ST_FINISH = 2'd2
  } state_e;

endpackage

### rtl/white_blob_centroid_steer.sv
// Pixel stream centroid tracker: band accumulation, serial divide and steering decision.
// Pixels are accepted one per cycle while accumulating; a frame-end pixel starts a
// restoring divider that retires one quotient bit per cycle (skipped when no white pixel
// was found), and pixels are held off until the result is loaded into the output
// register. A result not yet taken holds the block in its last step. Reset (asynchronous,
// active low) clears counters, accumulators and the sequencer and loads the
// configuration registers with their default values.
module white_blob_centroid_steer #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wbcs_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [wbcs_pkg::CfgDatW-1:0]    cfg_data_i,
  // Pixel input channel.
  input  logic                            pix_valid_i,
  output logic                            pix_ready_o,
  input  logic [wbcs_pkg::PixW-1:0]       pixel_value_i,
  input  logic                            frame_end_i,
  // Result output channel.
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output logic [1:0]                      steer_code_o,
  output logic [wbcs_pkg::ColOutW-1:0]    center_column_o,
  output logic [wbcs_pkg::CountW-1:0]     white_total_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned WW = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int unsigned BW = (RW > 10) ? RW : 10;
  localparam int unsigned SW = wbcs_pkg::SumW;
  localparam int unsigned NW = wbcs_pkg::CountW;
  localparam int unsigned IW = wbcs_pkg::IterW;

  // Configuration registers.
  logic [10:0]                 frame_width_q;
  logic [9:0]                  band_first_q, band_last_q;
  logic [wbcs_pkg::PixW-1:0]   white_level_q;
  logic [9:0]                  left_bound_q, right_bound_q;
  logic [NW-1:0]               near_count_q;

  // Frame accumulators.
  logic [CW-1:0] col_q, col_d, col0;
  logic [RW-1:0] row_q, row_d, row0;
  logic [SW-1:0] sum_q, sum_d;
  logic [NW-1:0] count_q, count_d;

  // Divider and result registers.
  wbcs_pkg::state_e        state_q, state_d;
  logic [SW-1:0]           quo_q, quo_d;
  logic [NW-1:0]           rem_q, rem_d;
  logic [NW-1:0]           div_q;
  logic [IW-1:0]           iter_q, iter_d;
  logic                    res_valid_q;
  wbcs_pkg::steer_e        steer_q;
  logic [wbcs_pkg::ColOutW-1:0] center_q;
  logic [NW-1:0]           total_q;

  logic pix_xfer, cfg_xfer, load_result;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign pix_ready_o = (state_q == wbcs_pkg::ST_ACCUM);
  assign pix_xfer    = pix_valid_i && pix_ready_o;

  // Configuration register writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= wbcs_pkg::FrameWidthRst;
      band_first_q  <= wbcs_pkg::BandFirstRowRst;
      band_last_q   <= wbcs_pkg::BandLastRowRst;
      white_level_q <= wbcs_pkg::WhiteLevelRst;
      left_bound_q  <= wbcs_pkg::LeftBoundRst;
      right_bound_q <= wbcs_pkg::RightBoundRst;
      near_count_q  <= wbcs_pkg::NearCountRst;
    end else if (cfg_xfer) begin
      case (cfg_index_i)
        wbcs_pkg::RegFrameWidth:   frame_width_q <= cfg_data_i[10:0];
        wbcs_pkg::RegBandFirstRow: band_first_q  <= cfg_data_i[9:0];
        wbcs_pkg::RegBandLastRow:  band_last_q   <= cfg_data_i[9:0];
        wbcs_pkg::RegWhiteLevel:   white_level_q <= cfg_data_i[wbcs_pkg::PixW-1:0];
        wbcs_pkg::RegLeftBound:    left_bound_q  <= cfg_data_i[9:0];
        wbcs_pkg::RegRightBound:   right_bound_q <= cfg_data_i[9:0];
        wbcs_pkg::RegNearCount:    near_count_q  <= cfg_data_i[NW-1:0];
        default: ;
      endcase
    end
  end

  // Row counter increment with wrap at the frame height.
  function automatic logic [RW-1:0] row_next(input logic [RW-1:0] row);
    if (row == RW'(MAX_HEIGHT - 1)) begin
      row_next = '0;
    end else begin
      row_next = row + 1'b1;
    end
  endfunction

  // Position tracking and band accumulation for one pixel.
  logic [WW-1:0] eff_width, col1;
  logic [SW:0]   sum_add;
  logic          in_band, is_white;

  always_comb begin
    // Clamp the programmed width into 1..MAX_WIDTH.
    eff_width = WW'(frame_width_q);
    if (eff_width == '0) begin
      eff_width = WW'(1);
    end else if (eff_width > WW'(MAX_WIDTH)) begin
      eff_width = WW'(MAX_WIDTH);
    end

    // A width lowered mid-row starts a new row first.
    if (WW'(col_q) >= eff_width) begin
      col0 = '0;
      row0 = row_next(row_q);
    end else begin
      col0 = col_q;
      row0 = row_q;
    end

    col1 = WW'(col0) + 1'b1;
    if (col1 >= eff_width) begin
      col_d = '0;
      row_d = row_next(row0);
    end else begin
      col_d = col1[CW-1:0];
      row_d = row0;
    end

    in_band  = (BW'(row0) >= BW'(band_first_q)) && (BW'(row0) <= BW'(band_last_q));
    is_white = in_band && (pixel_value_i == white_level_q);

    // Saturating sum and count.
    sum_add = {1'b0, sum_q} + (SW + 1)'(col0);
    sum_d   = sum_q;
    count_d = count_q;
    if (is_white) begin
      sum_d = sum_add[SW] ? '1 : sum_add[SW-1:0];
      if (count_q != '1) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      sum_q   <= '0;
      count_q <= '0;
    end else if (pix_xfer) begin
      if (frame_end_i) begin
        col_q   <= '0;
        row_q   <= '0;
        sum_q   <= '0;
        count_q <= '0;
      end else begin
        col_q   <= col_d;
        row_q   <= row_d;
        sum_q   <= sum_d;
        count_q <= count_d;
      end
    end
  end

  // Restoring divide step: one trial subtract per cycle in the divide state.
  logic [NW:0] trial, trial_diff;
  logic        q_bit;

  assign trial      = {rem_q, quo_q[SW-1]};
  assign trial_diff = trial - {1'b0, div_q};
  assign q_bit      = !trial_diff[NW];

  // Sequencer: accumulate, divide (skipped when no white pixel was counted), then hand over the result.
  always_comb begin
    state_d     = state_q;
    iter_d      = iter_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    load_result = 1'b0;
    case (state_q)
      wbcs_pkg::ST_ACCUM: begin
        if (pix_xfer && frame_end_i) begin
          quo_d   = sum_d;
          rem_d   = '0;
          iter_d  = '0;
          state_d = (count_d == '0) ? wbcs_pkg::ST_FINISH : wbcs_pkg::ST_DIVIDE;
        end
      end
      wbcs_pkg::ST_DIVIDE: begin
        quo_d  = {quo_q[SW-2:0], q_bit};
        rem_d  = q_bit ? trial_diff[NW-1:0] : trial[NW-1:0];
        iter_d = iter_q + 1'b1;
        if (iter_q == IW'(SW - 1)) begin
          state_d = wbcs_pkg::ST_FINISH;
        end
      end
      wbcs_pkg::ST_FINISH: begin
        if (!res_valid_q || res_ready_i) begin
          load_result = 1'b1;
          state_d     = wbcs_pkg::ST_ACCUM;
        end
      end
      default: begin
        state_d = wbcs_pkg::ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wbcs_pkg::ST_ACCUM;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  // Divider datapath; the divisor is captured at the frame-end transfer.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (pix_xfer && frame_end_i) begin
      div_q <= count_d;
    end
  end

  // Steering decision from the clamped centroid.
  logic [wbcs_pkg::ColOutW-1:0] center_c;
  wbcs_pkg::steer_e             steer_c;

  always_comb begin
    if (div_q == '0) begin
      center_c = '0;
      steer_c  = wbcs_pkg::STEER_STOP;
    end else begin
      center_c = (quo_q > SW'(wbcs_pkg::CenterMax)) ? wbcs_pkg::CenterMax
                                                     : quo_q[wbcs_pkg::ColOutW-1:0];
      if (center_c < left_bound_q) begin
        steer_c = wbcs_pkg::STEER_LEFT;
      end else if (center_c < right_bound_q) begin
        steer_c = (div_q < near_count_q) ? wbcs_pkg::STEER_FORWARD : wbcs_pkg::STEER_STOP;
      end else begin
        steer_c = wbcs_pkg::STEER_RIGHT;
      end
    end
  end

  // Output register; a transfer frees it for the next frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (load_result) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_result) begin
      steer_q  <= steer_c;
      center_q <= center_c;
      total_q  <= div_q;
    end
  end

  assign res_valid_o     = res_valid_q;
  assign steer_code_o    = steer_q;
  assign center_column_o = center_q;
  assign white_total_o   = total_q;

endmodule
